// ===== design/kwm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwm_pkg
// Shared types and codes for the k-way timestamp merge block.
// ----------------------------------------------------------------------------
package kwm_pkg;

    localparam logic [2:0] ACT_CLEAR = 3'd0;
    localparam logic [2:0] ACT_LOAD  = 3'd1;
    localparam logic [2:0] ACT_BUILD = 3'd2;
    localparam logic [2:0] ACT_NEXT  = 3'd3;
    localparam logic [2:0] ACT_SEEK  = 3'd4;

    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_EOF  = 2'd1;
    localparam logic [1:0] STAT_FULL = 2'd2;

    typedef struct packed {
        logic [2:0]         action;
        logic [2:0]         source_sel;
        logic signed [63:0] time_value;
        logic [63:0]        record_handle;
        logic [7:0]         tie_rank;
    } kwm_in_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [63:0] out_time;
        logic [63:0]        out_handle;
    } kwm_out_t;

    // controller -> datapath
    typedef struct packed {
        logic latch;
        logic clear;
        logic load;
        logic bld_init;
        logic set_eof;
        logic scan_init;
        logic scan_step;
        logic emit_best;
        logic sel_best;
        logic rd_mid;
        logic append;
        logic src_inc;
        logic replace;
        logic remove;
        logic bs_init;
        logic bs_step;
        logic rp_max;
        logic emit;
    } kwm_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [2:0] action;
        logic       heap_empty;
        logic       scan_done;
        logic       src_done;
        logic       has_next;
        logic       bs_done;
        logic       seek_stop;
        logic       out_busy;
    } kwm_sts_t;

endpackage

// ===== design/kway_timestamp_merge.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kway_timestamp_merge
// Merges sorted per-source record lists by timestamp through a small heap.
// ----------------------------------------------------------------------------
// channel   dir  handshake          payload
// s_        in   s_valid/s_ready    kwm_in_t  (action, source, time, handle, rank)
// m_        out  m_valid/m_ready    kwm_out_t (status, time, handle)
// cfg_      in   cfg_wr_en          active_sources, 4 bits
//
// One beat in, one beat out, one item at a time. Build appends the head of each
// non-empty active source. Next takes the minimum by a linear min scan, one slot
// a cycle, then refills its slot from the same source or moves the last slot in.
// Seek drops heads earlier than the target; each dropped head is followed by a
// binary search on the single record memory read port, a push back of the
// source's new head if it has one, and the following scan.
// Reset is synchronous; the record memory is not cleared. A stalled result
// waits in the output register while the next item is taken and worked on;
// that item's result holds the sequencer until the output register frees.
// ----------------------------------------------------------------------------
module kway_timestamp_merge import kwm_pkg::*; #(
    parameter int NUM_SOURCES  = 8,
    parameter int SOURCE_DEPTH = 256,
    parameter int TIME_WIDTH   = 64
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  kwm_in_t    s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output kwm_out_t   m_data,
    input  logic       cfg_wr_en,
    input  logic [3:0] cfg_wr_data
);

    kwm_cmd_t cmd;
    kwm_sts_t sts;

    kwm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    kwm_datapath #(
        .NUM_SOURCES  (NUM_SOURCES),
        .SOURCE_DEPTH (SOURCE_DEPTH),
        .TIME_WIDTH   (TIME_WIDTH)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_data      (s_data),
        .cmd         (cmd),
        .sts         (sts),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

endmodule

// ===== design/kwm_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwm_datapath
// Record memory, per-source counters, heap slots, min scan and binary search.
// ----------------------------------------------------------------------------
module kwm_datapath import kwm_pkg::*; #(
    parameter int NUM_SOURCES  = 8,
    parameter int SOURCE_DEPTH = 256,
    parameter int TIME_WIDTH   = 64
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  kwm_in_t    s_data,
    input  kwm_cmd_t   cmd,
    output kwm_sts_t   sts,
    input  logic       cfg_wr_en,
    input  logic [3:0] cfg_wr_data,
    output logic       m_valid,
    input  logic       m_ready,
    output kwm_out_t   m_data
);

    localparam int SRC_W     = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
    localparam int IDX_W     = $clog2(NUM_SOURCES + 1);
    localparam int FILL_W    = $clog2(SOURCE_DEPTH + 1);
    localparam int MEM_DEPTH = NUM_SOURCES * SOURCE_DEPTH;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);

    typedef logic signed [TIME_WIDTH-1:0] ts_t;

    kwm_in_t            item_reg;
    kwm_out_t           res_reg;
    kwm_out_t           out_reg;
    logic               m_valid_reg;
    logic [3:0]         active_reg;
    logic [FILL_W-1:0]  fill_reg [NUM_SOURCES];
    logic [FILL_W-1:0]  rp_reg   [NUM_SOURCES];
    logic [7:0]         rank_reg [NUM_SOURCES];
    ts_t                hp_ts_reg     [NUM_SOURCES];
    logic [63:0]        hp_handle_reg [NUM_SOURCES];
    logic [7:0]         hp_rank_reg   [NUM_SOURCES];
    logic [SRC_W-1:0]   hp_src_reg    [NUM_SOURCES];
    logic [IDX_W-1:0]   count_reg;
    logic [IDX_W-1:0]   cur_reg;
    logic [IDX_W-1:0]   scan_reg;
    ts_t                best_ts_reg;
    logic [63:0]        best_handle_reg;
    logic [7:0]         best_rank_reg;
    logic [SRC_W-1:0]   best_src_reg;
    logic [SRC_W-1:0]   best_slot_reg;
    logic [FILL_W-1:0]  lo_reg;
    logic [FILL_W-1:0]  hi_reg;
    ts_t                rec_time_reg   [MEM_DEPTH];
    logic [63:0]        rec_handle_reg [MEM_DEPTH];
    ts_t                rd_time_reg;
    logic [63:0]        rd_handle_reg;

    logic [SRC_W-1:0]   cur_idx;
    logic [SRC_W-1:0]   sel_idx;
    logic               sel_ok;
    logic               full;
    ts_t                target;
    logic [FILL_W-1:0]  mid;
    logic [FILL_W-1:0]  rd_pos;
    logic [ADDR_W-1:0]  rd_addr;
    logic [ADDR_W-1:0]  wr_addr;
    logic [IDX_W-1:0]   hp_raddr;
    logic [SRC_W-1:0]   hp_ridx;
    logic [SRC_W-1:0]   hp_widx;
    logic               cand_less;

    // order: timestamp, then tie rank, then source index
    function automatic logic item_less(ts_t at, logic [7:0] ar, logic [SRC_W-1:0] as,
                                       ts_t bt, logic [7:0] br, logic [SRC_W-1:0] bs);
        logic r;
        if (at != bt) r = at < bt;
        else if (ar != br) r = ar < br;
        else r = as < bs;
        return r;
    endfunction

    assign cur_idx  = cur_reg[SRC_W-1:0];
    assign sel_idx  = SRC_W'(item_reg.source_sel);
    assign sel_ok   = int'(item_reg.source_sel) < NUM_SOURCES;
    assign full     = fill_reg[sel_idx] == FILL_W'(SOURCE_DEPTH);
    assign target   = item_reg.time_value[TIME_WIDTH-1:0];
    assign mid      = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign rd_pos   = cmd.rd_mid ? mid : rp_reg[cur_idx];
    assign rd_addr  = ADDR_W'(cur_idx) * ADDR_W'(SOURCE_DEPTH) + ADDR_W'(rd_pos);
    assign wr_addr  = ADDR_W'(sel_idx) * ADDR_W'(SOURCE_DEPTH) + ADDR_W'(fill_reg[sel_idx]);
    assign hp_raddr = cmd.remove ? (count_reg - 1'b1) : scan_reg;
    assign hp_ridx  = hp_raddr[SRC_W-1:0];
    assign hp_widx  = count_reg[SRC_W-1:0];
    assign cand_less = item_less(hp_ts_reg[hp_ridx], hp_rank_reg[hp_ridx], hp_src_reg[hp_ridx],
                                 best_ts_reg, best_rank_reg, best_src_reg);

    always_comb begin
        sts.action     = item_reg.action;
        sts.heap_empty = count_reg == '0;
        sts.scan_done  = scan_reg >= count_reg;
        sts.src_done   = (int'(cur_reg) >= int'(active_reg)) || (int'(cur_reg) >= NUM_SOURCES);
        sts.has_next   = rp_reg[cur_idx] < fill_reg[cur_idx];
        sts.bs_done    = lo_reg >= hi_reg;
        sts.seek_stop  = !(best_ts_reg < target);
        sts.out_busy   = m_valid_reg && !m_ready;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    // record memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (cmd.load && sel_ok && !full) begin
            rec_time_reg[wr_addr]   <= item_reg.time_value[TIME_WIDTH-1:0];
            rec_handle_reg[wr_addr] <= item_reg.record_handle;
        end
        rd_time_reg   <= rec_time_reg[rd_addr];
        rd_handle_reg <= rec_handle_reg[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_SOURCES; i++) begin
                fill_reg[i] <= '0;
                rp_reg[i]   <= '0;
                rank_reg[i] <= '0;
            end
            count_reg   <= '0;
            active_reg  <= 4'd8;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) active_reg <= cfg_wr_data;
            if (cmd.latch) begin
                item_reg <= s_data;
                res_reg  <= '0;
            end
            if (cmd.clear) begin
                for (int i = 0; i < NUM_SOURCES; i++) begin
                    fill_reg[i] <= '0;
                    rp_reg[i]   <= '0;
                    rank_reg[i] <= '0;
                end
                count_reg <= '0;
            end
            if (cmd.load && sel_ok) begin
                if (full) begin
                    res_reg.status <= STAT_FULL;
                end else begin
                    fill_reg[sel_idx] <= fill_reg[sel_idx] + 1'b1;
                    rank_reg[sel_idx] <= item_reg.tie_rank;
                end
            end
            if (cmd.set_eof) res_reg.status <= STAT_EOF;
            if (cmd.bld_init) begin
                count_reg <= '0;
                cur_reg   <= '0;
            end
            if (cmd.src_inc) cur_reg <= cur_reg + 1'b1;
            if (cmd.append) begin
                hp_ts_reg[hp_widx]     <= rd_time_reg;
                hp_handle_reg[hp_widx] <= rd_handle_reg;
                hp_rank_reg[hp_widx]   <= rank_reg[cur_idx];
                hp_src_reg[hp_widx]    <= cur_idx;
                count_reg              <= count_reg + 1'b1;
                rp_reg[cur_idx]        <= rp_reg[cur_idx] + 1'b1;
            end
            if (cmd.scan_init) begin
                scan_reg        <= IDX_W'(1);
                best_ts_reg     <= hp_ts_reg[0];
                best_handle_reg <= hp_handle_reg[0];
                best_rank_reg   <= hp_rank_reg[0];
                best_src_reg    <= hp_src_reg[0];
                best_slot_reg   <= '0;
            end
            if (cmd.scan_step) begin
                if (cand_less) begin
                    best_ts_reg     <= hp_ts_reg[hp_ridx];
                    best_handle_reg <= hp_handle_reg[hp_ridx];
                    best_rank_reg   <= hp_rank_reg[hp_ridx];
                    best_src_reg    <= hp_src_reg[hp_ridx];
                    best_slot_reg   <= hp_ridx;
                end
                scan_reg <= scan_reg + 1'b1;
            end
            if (cmd.emit_best) begin
                res_reg.out_time   <= 64'(best_ts_reg);
                res_reg.out_handle <= best_handle_reg;
            end
            if (cmd.sel_best) cur_reg <= IDX_W'(best_src_reg);
            if (cmd.replace) begin
                hp_ts_reg[best_slot_reg]     <= rd_time_reg;
                hp_handle_reg[best_slot_reg] <= rd_handle_reg;
                hp_rank_reg[best_slot_reg]   <= best_rank_reg;
                hp_src_reg[best_slot_reg]    <= best_src_reg;
                rp_reg[cur_idx]              <= rp_reg[cur_idx] + 1'b1;
            end
            // last slot moves into the hole
            if (cmd.remove) begin
                count_reg                    <= count_reg - 1'b1;
                hp_ts_reg[best_slot_reg]     <= hp_ts_reg[hp_ridx];
                hp_handle_reg[best_slot_reg] <= hp_handle_reg[hp_ridx];
                hp_rank_reg[best_slot_reg]   <= hp_rank_reg[hp_ridx];
                hp_src_reg[best_slot_reg]    <= hp_src_reg[hp_ridx];
            end
            if (cmd.bs_init) begin
                lo_reg <= '0;
                hi_reg <= fill_reg[cur_idx];
            end
            if (cmd.bs_step) begin
                if (rd_time_reg < target) lo_reg <= mid + 1'b1;
                else hi_reg <= mid;
            end
            if (cmd.rp_max && (lo_reg > rp_reg[cur_idx])) rp_reg[cur_idx] <= lo_reg;
            // output beat has its own register so the next item can be worked on
            if (cmd.emit) out_reg <= res_reg;
            if (cmd.emit) m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;
        end
    end

endmodule

// ===== design/kwm_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwm_ctrl
// Sequencer for the merge actions: build, next, seek and the single-step ones.
// ----------------------------------------------------------------------------
module kwm_ctrl import kwm_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  kwm_sts_t sts,
    output kwm_cmd_t cmd
);

    typedef enum logic [17:0] {
        ST_IDLE    = 18'h00001,
        ST_DECODE  = 18'h00002,
        ST_BLD_CHK = 18'h00004,
        ST_BLD_WR  = 18'h00008,
        ST_SCAN    = 18'h00010,
        ST_NXT_TAK = 18'h00020,
        ST_NXT_CHK = 18'h00040,
        ST_NXT_WR  = 18'h00080,
        ST_SK_CHK  = 18'h00100,
        ST_BS_INIT = 18'h00200,
        ST_BS_CHK  = 18'h00400,
        ST_BS_CMP  = 18'h00800,
        ST_SK_PUSH = 18'h01000,
        ST_SK_WR   = 18'h02000,
        ST_SK_LOOP = 18'h04000,
        ST_RESP    = 18'h08000,
        ST_SPARE_A = 18'h10000,
        ST_SPARE_B = 18'h20000
    } state_t;

    state_t state_reg, state_next;

    assign s_ready = state_reg == ST_IDLE;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.latch  = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                state_next = ST_RESP;
                case (sts.action)
                    ACT_CLEAR: cmd.clear = 1'b1;
                    ACT_LOAD:  cmd.load  = 1'b1;
                    ACT_BUILD: begin
                        cmd.bld_init = 1'b1;
                        state_next   = ST_BLD_CHK;
                    end
                    ACT_NEXT: begin
                        if (sts.heap_empty) begin
                            cmd.set_eof = 1'b1;
                        end else begin
                            cmd.scan_init = 1'b1;
                            state_next    = ST_SCAN;
                        end
                    end
                    ACT_SEEK: begin
                        if (!sts.heap_empty) begin
                            cmd.scan_init = 1'b1;
                            state_next    = ST_SCAN;
                        end
                    end
                    default: state_next = ST_RESP;
                endcase
            end
            ST_BLD_CHK: begin
                if (sts.src_done) state_next = ST_RESP;
                else if (sts.has_next) state_next = ST_BLD_WR;
                else cmd.src_inc = 1'b1;
            end
            ST_BLD_WR: begin
                cmd.append  = 1'b1;
                cmd.src_inc = 1'b1;
                state_next  = ST_BLD_CHK;
            end
            ST_SCAN: begin
                if (sts.scan_done) begin
                    state_next = (sts.action == ACT_NEXT) ? ST_NXT_TAK : ST_SK_CHK;
                end else begin
                    cmd.scan_step = 1'b1;
                end
            end
            ST_NXT_TAK: begin
                cmd.emit_best = 1'b1;
                cmd.sel_best  = 1'b1;
                state_next    = ST_NXT_CHK;
            end
            ST_NXT_CHK: begin
                if (sts.has_next) begin
                    state_next = ST_NXT_WR;
                end else begin
                    cmd.remove = 1'b1;
                    state_next = ST_RESP;
                end
            end
            ST_NXT_WR: begin
                cmd.replace = 1'b1;
                state_next  = ST_RESP;
            end
            ST_SK_CHK: begin
                if (sts.seek_stop) begin
                    state_next = ST_RESP;
                end else begin
                    cmd.remove   = 1'b1;
                    cmd.sel_best = 1'b1;
                    state_next   = ST_BS_INIT;
                end
            end
            ST_BS_INIT: begin
                cmd.bs_init = 1'b1;
                state_next  = ST_BS_CHK;
            end
            ST_BS_CHK: begin
                if (sts.bs_done) begin
                    cmd.rp_max = 1'b1;
                    state_next = ST_SK_PUSH;
                end else begin
                    cmd.rd_mid = 1'b1;
                    state_next = ST_BS_CMP;
                end
            end
            ST_BS_CMP: begin
                cmd.bs_step = 1'b1;
                state_next  = ST_BS_CHK;
            end
            ST_SK_PUSH: begin
                state_next = sts.has_next ? ST_SK_WR : ST_SK_LOOP;
            end
            ST_SK_WR: begin
                cmd.append = 1'b1;
                state_next = ST_SK_LOOP;
            end
            ST_SK_LOOP: begin
                if (sts.heap_empty) begin
                    state_next = ST_RESP;
                end else begin
                    cmd.scan_init = 1'b1;
                    state_next    = ST_SCAN;
                end
            end
            ST_RESP: begin
                if (!sts.out_busy) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_IDLE;
        else state_reg <= state_next;
    end

endmodule

// ===== design/kwm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwm_checker
// Port-level checks for the merge block, bound to the top level.
// ----------------------------------------------------------------------------
module kwm_checker import kwm_pkg::*; (
    input logic     aclk,
    input logic     aresetn,
    input logic     s_valid,
    input logic     s_ready,
    input logic     m_valid,
    input logic     m_ready,
    input kwm_out_t m_data
);

    // one item at a time: input closes right after a beat
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken on consecutive cycles");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.status != 2'd3)
        else $error("bad status code");

    a_zero_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != STAT_OK |-> m_data.out_time == '0 && m_data.out_handle == '0)
        else $error("record fields set on non-ok result");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind kway_timestamp_merge kwm_checker u_kwm_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
